/* rtl/core/cfbp_pkg.sv */
// Shared types, codes, tables and helper functions of the configuration frame bit patcher.
package cfbp_pkg;

   localparam int FRAME_WORDS        = 101;
   localparam int ROWS_PER_CLOCK_ROW = 50;
   localparam int SKIP_ENTRIES       = 15;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOAD   = 2'd0;
   localparam kind_type KIND_SET    = 2'd1;
   localparam kind_type KIND_READ   = 2'd2;
   localparam kind_type KIND_LOCATE = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_GROUP = 2'd2;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_FRAME_BASE = 2'd0;
   localparam reg_index_type REG_ANCHOR_ROW = 2'd1;
   localparam reg_index_type REG_ANCHOR_COL = 2'd2;

   localparam logic [5:0] FRAME_BASE_RESET = 6'd26;

   // Major column positions that hold no CLB columns; the last entry is a sentinel.
   localparam logic [15:0] SKIP_COLS [16] = '{
      16'd0,  16'd0,  16'd4,  16'd6,  16'd10, 16'd12, 16'd16, 16'd18,
      16'd25, 16'd27, 16'd40, 16'd45, 16'd47, 16'd51, 16'd53, 16'hFFFF
   };

   typedef struct packed {
      logic [6:0] major_column;
      logic       bottom_half;
      logic       clk_row;
      logic [6:0] word_pos;
   } locate_type;

   // Clock row group of a slice row: row / 50, for rows 0 to 255.
   function automatic logic [2:0] row_group(input logic [7:0] row);
      logic [2:0] g;
      if (row < 8'd50) begin
         g = 3'd0;
      end else if (row < 8'd100) begin
         g = 3'd1;
      end else if (row < 8'd150) begin
         g = 3'd2;
      end else if (row < 8'd200) begin
         g = 3'd3;
      end else if (row < 8'd250) begin
         g = 3'd4;
      end else begin
         g = 3'd5;
      end
      return g;
   endfunction

   // Word offset of a slice row inside a frame; the upper half of a clock row
   // skips the clock word in the middle of the frame.
   function automatic logic [6:0] row_word_pos(input logic [7:0] row);
      logic [7:0] grp_base;
      logic [5:0] r;
      grp_base = 8'(32'(row_group(row)) * ROWS_PER_CLOCK_ROW);
      r = 6'(row - grp_base);
      if (r >= 6'(ROWS_PER_CLOCK_ROW / 2)) begin
         return {r, 1'b1};
      end else begin
         return {r, 1'b0};
      end
   endfunction

endpackage

/* rtl/core/cfbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfbp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 404
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/cfbp_locate.sv */
// Maps a slice coordinate to major column, device half, clock row and word offset.
module cfbp_locate (
   input  logic [7:0]           tile_row,
   input  logic [6:0]           tile_col,
   output cfbp_pkg::locate_type loc
);
   import cfbp_pkg::*;

   always_comb begin
      logic [5:0] half_col;
      logic [3:0] skipped;
      logic [2:0] grp;
      half_col = tile_col[6:1];
      skipped  = 4'd0;
      // The skip table is sorted, so counting entries not above the column
      // gives the number of non-CLB columns before it.
      for (int i = 0; i < SKIP_ENTRIES; i++) begin
         if (16'(half_col) >= SKIP_COLS[i]) begin
            skipped = skipped + 4'd1;
         end
      end
      grp = row_group(tile_row);
      loc.major_column = 7'(half_col) + 7'(skipped);
      loc.bottom_half  = (grp < 3'd2);
      loc.clk_row      = (grp == 3'd0) || (grp >= 3'd3);
      loc.word_pos     = row_word_pos(tile_row);
   end

endmodule

/* rtl/core/config_frame_bit_patcher_top.sv */
// Top level of the configuration frame bit patcher: frame buffer, bit patching and slice locate.
//
// The block takes one transaction per clock cycle and never raises busy. Each transaction
// gives exactly one result, strobed by rsp_valid for one cycle once it has passed the
// merge and result registers. The receiver cannot hold results off: it must take each result
// in the cycle in which it is strobed. The frame buffer is a RAM of FRAMES*101 words with a
// registered read port: the address stage computes the word address and issues the read,
// the merge stage merges the patched bit (or takes the load data), writes the word back and
// registers the result. A write from the directly preceding transaction is forwarded, so
// back-to-back patches of one word are exact. The buffer is not cleared by reset; reading
// a word that was never loaded returns undefined data. Configuration registers sit at byte
// addresses 0, 4 and 8 and must only be written while no transaction is in flight.
module config_frame_bit_patcher_top #(
   parameter int FRAMES = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Transaction request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_word_index,
   input  logic [31:0] req_word_data,
   input  logic [7:0]  req_tile_row,
   input  logic [6:0]  req_tile_col,
   input  logic [5:0]  req_frame_id,
   input  logic [5:0]  req_bit_number,
   input  logic        req_bit_value,
   // Result
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_major_column,
   output logic        rsp_bottom_half,
   output logic        rsp_clk_row,
   output logic [6:0]  rsp_word_pos,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cfbp_pkg::*;

   localparam int STORE_WORDS = FRAMES * FRAME_WORDS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int POS_W       = ADDR_W + 1;
   localparam int FIDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // ---------------- Configuration registers ----------------
   logic [5:0] frame_base_ff;
   logic [7:0] anchor_row_ff;
   logic [6:0] anchor_col_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= FRAME_BASE_RESET;
         anchor_row_ff <= 8'd0;
         anchor_col_ff <= 7'd0;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_FRAME_BASE: frame_base_ff <= pwdata[5:0];
            REG_ANCHOR_ROW: anchor_row_ff <= pwdata[7:0];
            REG_ANCHOR_COL: anchor_col_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FRAME_BASE: prdata = {26'd0, frame_base_ff};
         REG_ANCHOR_ROW: prdata = {24'd0, anchor_row_ff};
         REG_ANCHOR_COL: prdata = {25'd0, anchor_col_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // ---------------- Stage 0: address and checks ----------------
   logic              go;
   logic [6:0]        rel;
   logic              group_ok;
   logic              frame_ok;
   logic              widx_ok;
   logic [POS_W-1:0]  pos;
   logic [ADDR_W-1:0] addr_in;
   status_type        status_in;
   logic              wen_in;

   assign busy = 1'b0;
   assign go   = start && !busy;

   assign rel      = {1'b0, req_frame_id} - {1'b0, frame_base_ff};
   assign group_ok = (req_tile_col == anchor_col_ff) &&
                     (row_group(req_tile_row) == row_group(anchor_row_ff));
   assign frame_ok = (req_frame_id >= frame_base_ff) && (rel < 7'(FRAMES));
   assign widx_ok  = 32'(req_word_index) < 32'(STORE_WORDS);
   // Bit numbers from 32 up live in the row's first word, lower ones in the word after it.
   assign pos = POS_W'(rel[FIDX_W-1:0]) * POS_W'(FRAME_WORDS)
              + POS_W'(row_word_pos(req_tile_row))
              + POS_W'(!req_bit_number[5]);

   always_comb begin
      addr_in   = ADDR_W'(req_word_index);
      status_in = STATUS_OK;
      wen_in    = 1'b0;
      case (req_kind)
         KIND_LOAD: begin
            wen_in = widx_ok;
            if (!widx_ok) status_in = STATUS_RANGE;
         end
         KIND_READ: begin
            if (!widx_ok) status_in = STATUS_RANGE;
         end
         KIND_SET: begin
            addr_in = ADDR_W'(pos);
            if (!group_ok) begin
               status_in = STATUS_GROUP;
            end else if (!frame_ok || (pos >= POS_W'(STORE_WORDS))) begin
               status_in = STATUS_RANGE;
            end else begin
               wen_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- Stage 1 registers ----------------
   logic              s1_valid_ff;
   kind_type          s1_kind_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [31:0]       s1_wdata_ff;
   status_type        s1_status_ff;
   logic              s1_wen_ff;
   logic [4:0]        s1_bit_ff;
   logic              s1_bval_ff;
   logic [7:0]        s1_row_ff;
   logic [6:0]        s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= go;
      end
      if (go) begin
         s1_kind_ff   <= req_kind;
         s1_addr_ff   <= addr_in;
         s1_wdata_ff  <= req_word_data;
         s1_status_ff <= status_in;
         s1_wen_ff    <= wen_in;
         s1_bit_ff    <= req_bit_number[4:0];
         s1_bval_ff   <= req_bit_value;
         s1_row_ff    <= req_tile_row;
         s1_col_ff    <= req_tile_col;
      end
   end

   // ---------------- Frame buffer ----------------
   logic              ram_we;
   logic [31:0]       ram_rdata;
   logic [31:0]       wr_data_in;

   cfbp_ram #(
      .WIDTH (32),
      .DEPTH (STORE_WORDS)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_addr_ff),
      .wdata (wr_data_in),
      .re    (go),
      .raddr (addr_in),
      .rdata (ram_rdata)
   );

   // ---------------- Stage 1: merge and write back ----------------
   logic              lw_valid_ff;
   logic [ADDR_W-1:0] lw_addr_ff;
   logic [31:0]       lw_data_ff;
   logic [31:0]       old_word;
   logic [31:0]       bit_mask;

   // The RAM read of this transaction happened on the same edge as the previous
   // write, so that write is taken from the bypass register instead.
   assign old_word = (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : ram_rdata;
   assign bit_mask = 32'd1 << s1_bit_ff;
   assign ram_we   = s1_valid_ff && s1_wen_ff;

   always_comb begin
      case (s1_kind_ff)
         KIND_LOAD: wr_data_in = s1_wdata_ff;
         default:   wr_data_in = s1_bval_ff ? (old_word | bit_mask) : (old_word & ~bit_mask);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= ram_we;
      end
      lw_addr_ff <= s1_addr_ff;
      lw_data_ff <= wr_data_in;
   end

   locate_type loc;

   cfbp_locate u_locate (
      .tile_row (s1_row_ff),
      .tile_col (s1_col_ff),
      .loc      (loc)
   );

   // ---------------- Result registers ----------------
   logic        rsp_valid_ff;
   logic [31:0] rsp_read_data_ff;
   status_type  rsp_status_ff;
   locate_type  rsp_loc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         rsp_status_ff    <= s1_status_ff;
         rsp_read_data_ff <= ((s1_kind_ff == KIND_READ) && (s1_status_ff == STATUS_OK)) ?
                             old_word : 32'd0;
         rsp_loc_ff       <= (s1_kind_ff == KIND_LOCATE) ? loc : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_major_column = rsp_loc_ff.major_column;
   assign rsp_bottom_half  = rsp_loc_ff.bottom_half;
   assign rsp_clk_row      = rsp_loc_ff.clk_row;
   assign rsp_word_pos     = rsp_loc_ff.word_pos;

`ifndef NO_ASSERTIONS
   // Every accepted transaction produces its result after the merge and result registers.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      go |=> ##1 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   // The buffer is only written by transactions that passed their checks.
   a_write_only_ok: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (s1_status_ff == STATUS_OK) &&
                 ((s1_kind_ff == KIND_LOAD) || (s1_kind_ff == KIND_SET)))
      else $error("frame buffer written by a failing or non-writing transaction");

   // A failed transaction never returns buffer data.
   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_read_data == 32'd0))
      else $error("read data returned with an error status");
`endif

endmodule

/* tb/sv/config_frame_bit_patcher_top_test.sv */
// Self-checking testbench of the configuration frame bit patcher top level.
module config_frame_bit_patcher_top_test;
   import cfbp_pkg::*;

   localparam int BUFFER_FRAMES   = 4;
   localparam int BUFFER_WORDS    = BUFFER_FRAMES * FRAME_WORDS;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PRINT_LIMIT     = 100;

   // Major column positions that hold no CLB columns, in ascending order.
   localparam int COLUMN_SKIPS [15] = '{0, 0, 4, 6, 10, 12, 16, 18, 25, 27, 40, 45, 47, 51, 53};

   // Register settings of the random phases; frame base takes both its extremes, 0 and 63.
   localparam int PHASE_BASE [6] = '{32, 0, 63, 60, 26, 5};
   localparam int PHASE_ROW  [6] = '{149, 0, 99, 50, 120, 25};
   localparam int PHASE_COL  [6] = '{113, 0, 57, 1, 40, 112};

   typedef struct packed {
      kind_type    kind;
      logic [8:0]  word_index;
      logic [31:0] word_data;
      logic [7:0]  tile_row;
      logic [6:0]  tile_col;
      logic [5:0]  frame_id;
      logic [5:0]  bit_number;
      logic        bit_value;
   } patch_request_type;

   typedef struct packed {
      logic [31:0] read_data;
      status_type  status;
      logic [6:0]  major_column;
      logic        bottom_half;
      logic        clk_row;
      logic [6:0]  word_pos;
   } patch_result_type;

   // Tracks the frame buffer and registers and predicts the result of every transaction.
   class frame_buffer_tracker;
      logic [31:0]      buffer_words [BUFFER_WORDS];
      bit               word_loaded [BUFFER_WORDS];
      int               loaded_list [$];
      logic [5:0]       frame_base;
      logic [7:0]       anchor_row;
      logic [6:0]       anchor_col;
      patch_result_type pending_results [$];
      int               mismatch_count;
      int               result_count;
      int               register_writes;
      int               kind_count [4];
      int               status_count [4];

      function new();
         frame_base = FRAME_BASE_RESET;
         anchor_row = '0;
         anchor_col = '0;
         mismatch_count = 0;
         result_count = 0;
         register_writes = 0;
         foreach (word_loaded[i]) word_loaded[i] = 1'b0;
         foreach (kind_count[i]) kind_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function void set_register(input reg_index_type idx, input logic [31:0] value);
         register_writes++;
         case (idx)
            REG_FRAME_BASE: frame_base = value[5:0];
            REG_ANCHOR_ROW: anchor_row = value[7:0];
            REG_ANCHOR_COL: anchor_col = value[6:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(input reg_index_type idx);
         case (idx)
            REG_FRAME_BASE: return 32'(frame_base);
            REG_ANCHOR_ROW: return 32'(anchor_row);
            REG_ANCHOR_COL: return 32'(anchor_col);
            default: return '0;
         endcase
      endfunction

      // Rows in the upper half of a clock row skip the clock word in the middle of the frame.
      function int row_offset(input logic [7:0] row);
         int r;
         r = row % ROWS_PER_CLOCK_ROW;
         return (r >= ROWS_PER_CLOCK_ROW / 2) ? 2 * r + 1 : 2 * r;
      endfunction

      function status_type patch_target(input logic [7:0] row, input logic [6:0] col,
                                        input logic [5:0] frame, input logic [5:0] bitn,
                                        output int word, output int bitpos);
         int rel;
         word = -1;
         bitpos = 0;
         if (col != anchor_col ||
             row / ROWS_PER_CLOCK_ROW != anchor_row / ROWS_PER_CLOCK_ROW) begin
            return STATUS_GROUP;
         end
         rel = int'(frame) - int'(frame_base);
         if (rel < 0 || rel >= BUFFER_FRAMES) begin
            return STATUS_RANGE;
         end
         word = rel * FRAME_WORDS + row_offset(row);
         // The upper 32 bits of the slice field sit in the row's first word.
         if (bitn >= 32) begin
            bitpos = int'(bitn) - 32;
         end else begin
            bitpos = int'(bitn);
            word++;
         end
         if (word >= BUFFER_WORDS) begin
            word = -1;
            return STATUS_RANGE;
         end
         return STATUS_OK;
      endfunction

      function void note_request(input patch_request_type rq);
         patch_result_type res;
         int               word;
         int               bitpos;
         int               grp;
         int               major;
         int               skipped;
         res = '0;
         kind_count[rq.kind]++;
         case (rq.kind)
            KIND_LOAD: begin
               if (rq.word_index < BUFFER_WORDS) begin
                  buffer_words[rq.word_index] = rq.word_data;
                  if (!word_loaded[rq.word_index]) begin
                     word_loaded[rq.word_index] = 1'b1;
                     loaded_list.push_back(int'(rq.word_index));
                  end
               end else begin
                  res.status = STATUS_RANGE;
               end
            end
            KIND_READ: begin
               if (rq.word_index < BUFFER_WORDS) begin
                  res.read_data = buffer_words[rq.word_index];
               end else begin
                  res.status = STATUS_RANGE;
               end
            end
            KIND_SET: begin
               res.status = patch_target(rq.tile_row, rq.tile_col, rq.frame_id,
                                         rq.bit_number, word, bitpos);
               if (res.status == STATUS_OK) begin
                  buffer_words[word][bitpos] = rq.bit_value;
               end
            end
            KIND_LOCATE: begin
               grp = rq.tile_row / ROWS_PER_CLOCK_ROW;
               major = rq.tile_col / 2;
               skipped = 0;
               foreach (COLUMN_SKIPS[k]) begin
                  if (major >= COLUMN_SKIPS[k]) skipped++;
               end
               res.major_column = 7'(major + skipped);
               // Groups 0 and 1 form the bottom half; rows below 50 and from 150 up get a clock row flag of 1.
               res.bottom_half = (grp < 2);
               res.clk_row = (grp == 0 || grp >= 3);
               res.word_pos = 7'(row_offset(rq.tile_row));
            end
            default: ;
         endcase
         status_count[res.status]++;
         pending_results.push_back(res);
      endfunction

      task report_mismatch(input string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
      endtask

      task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s is %h, expected %h",
                                      result_count, name, got, want));
         end
      endtask

      task check_result(input patch_result_type got);
         patch_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with status %0d arrived with none outstanding",
                                      got.status));
            return;
         end
         want = pending_results.pop_front();
         result_count++;
         compare_field("read_data", got.read_data, want.read_data);
         compare_field("status", 32'(got.status), 32'(want.status));
         compare_field("major_column", 32'(got.major_column), 32'(want.major_column));
         compare_field("bottom_half", 32'(got.bottom_half), 32'(want.bottom_half));
         compare_field("clk_row", 32'(got.clk_row), 32'(want.clk_row));
         compare_field("word_pos", 32'(got.word_pos), 32'(want.word_pos));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [8:0]  req_word_index;
   logic [31:0] req_word_data;
   logic [7:0]  req_tile_row;
   logic [6:0]  req_tile_col;
   logic [5:0]  req_frame_id;
   logic [5:0]  req_bit_number;
   logic        req_bit_value;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_major_column;
   logic        rsp_bottom_half;
   logic        rsp_clk_row;
   logic [6:0]  rsp_word_pos;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   frame_buffer_tracker tracker;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  last_patch_word = -1;
   bit                  have_last_patch = 1'b0;
   logic [7:0]          last_patch_row;
   logic [5:0]          last_patch_frame;

   config_frame_bit_patcher_top #(
      .FRAMES(BUFFER_FRAMES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_word_index   (req_word_index),
      .req_word_data    (req_word_data),
      .req_tile_row     (req_tile_row),
      .req_tile_col     (req_tile_col),
      .req_frame_id     (req_frame_id),
      .req_bit_number   (req_bit_number),
      .req_bit_value    (req_bit_value),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_major_column (rsp_major_column),
      .rsp_bottom_half  (rsp_bottom_half),
      .rsp_clk_row      (rsp_clk_row),
      .rsp_word_pos     (rsp_word_pos),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  tracker.pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Results are checked before the transaction taken at the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            tracker.check_result(patch_result_type'{rsp_read_data, rsp_status,
                                                    rsp_major_column, rsp_bottom_half,
                                                    rsp_clk_row, rsp_word_pos});
         end
         if (start && !busy) begin
            tracker.note_request(patch_request_type'{req_kind, req_word_index, req_word_data,
                                                     req_tile_row, req_tile_col,
                                                     req_frame_id, req_bit_number,
                                                     req_bit_value});
         end
      end
   end

   function automatic patch_request_type make_request(input kind_type kind, input int index,
                                                      input logic [31:0] data, input int row,
                                                      input int col, input int frame,
                                                      input int bitn, input bit bval);
      patch_request_type rq;
      rq.kind = kind;
      rq.word_index = 9'(index);
      rq.word_data = data;
      rq.tile_row = 8'(row);
      rq.tile_col = 7'(col);
      rq.frame_id = 6'(frame);
      rq.bit_number = 6'(bitn);
      rq.bit_value = bval;
      return rq;
   endfunction

   function automatic patch_request_type random_fields();
      patch_request_type rq;
      rq.kind = kind_type'($urandom_range(0, 3));
      rq.word_index = 9'($urandom_range(0, 511));
      rq.word_data = $urandom();
      rq.tile_row = 8'($urandom_range(0, 255));
      rq.tile_col = 7'($urandom_range(0, 127));
      rq.frame_id = 6'($urandom_range(0, 63));
      rq.bit_number = 6'($urandom_range(0, 63));
      rq.bit_value = 1'($urandom_range(0, 1));
      return rq;
   endfunction

   function automatic logic [7:0] row_in_anchor_group();
      int lo;
      int hi;
      lo = (tracker.anchor_row / ROWS_PER_CLOCK_ROW) * ROWS_PER_CLOCK_ROW;
      hi = (lo + ROWS_PER_CLOCK_ROW - 1 > 255) ? 255 : lo + ROWS_PER_CLOCK_ROW - 1;
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic patch_request_type random_request();
      patch_request_type rq;
      int                pick;
      int                span;
      int                rel;
      rq = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         rq.kind = KIND_LOAD;
         if ($urandom_range(0, 9) != 0) rq.word_index = 9'($urandom_range(0, BUFFER_WORDS - 1));
      end else if (pick < 60) begin
         rq.kind = KIND_SET;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // Patches that pass both checks; a third of them return to the row and frame of the last patch.
            if (have_last_patch && $urandom_range(0, 2) == 0) begin
               rq.tile_row = last_patch_row;
               rq.frame_id = last_patch_frame;
            end else begin
               span = 63 - int'(tracker.frame_base);
               if (span > BUFFER_FRAMES - 1) span = BUFFER_FRAMES - 1;
               rq.tile_row = row_in_anchor_group();
               rq.frame_id = 6'(int'(tracker.frame_base) + $urandom_range(0, span));
            end
            rq.tile_col = tracker.anchor_col;
            last_patch_row = rq.tile_row;
            last_patch_frame = rq.frame_id;
            have_last_patch = 1'b1;
         end else if (pick < 85) begin
            rq.tile_col = tracker.anchor_col;
            rq.tile_row = row_in_anchor_group();
            do begin
               rq.frame_id = 6'($urandom_range(0, 63));
               rel = int'(rq.frame_id) - int'(tracker.frame_base);
            end while (rel >= 0 && rel < BUFFER_FRAMES);
         end
      end else if (pick < 80) begin
         rq.kind = KIND_READ;
         pick = $urandom_range(0, 99);
         if (pick < 25 && last_patch_word >= 0) begin
            rq.word_index = 9'(last_patch_word);
         end else if (pick < 80 && tracker.loaded_list.size() > 0) begin
            rq.word_index = 9'(tracker.loaded_list[$urandom_range(0,
                                                  tracker.loaded_list.size() - 1)]);
         end else if (pick < 90) begin
            rq.word_index = 9'($urandom_range(BUFFER_WORDS, 511));
         end else begin
            rq.word_index = 9'($urandom_range(0, BUFFER_WORDS - 1));
         end
      end else begin
         rq.kind = KIND_LOCATE;
      end
      return rq;
   endfunction

   task automatic drive_raw(input patch_request_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      {req_kind, req_word_index, req_word_data, req_tile_row, req_tile_col,
       req_frame_id, req_bit_number, req_bit_value} = rq;
      start = 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   task automatic preload_word(input int word);
      patch_request_type fill;
      fill = random_fields();
      fill.kind = KIND_LOAD;
      fill.word_index = 9'(word);
      drive_raw(fill);
   endtask

   // A word is always loaded before anything reads it, a bit patch included.
   task automatic send_request(input patch_request_type rq);
      status_type st;
      int         word;
      int         bitpos;
      if (rq.kind == KIND_SET) begin
         st = tracker.patch_target(rq.tile_row, rq.tile_col, rq.frame_id,
                                   rq.bit_number, word, bitpos);
         if (st == STATUS_OK) begin
            last_patch_word = word;
            if (!tracker.word_loaded[word]) preload_word(word);
         end
      end else if (rq.kind == KIND_READ && rq.word_index < BUFFER_WORDS) begin
         if (!tracker.word_loaded[rq.word_index]) preload_word(int'(rq.word_index));
      end
      drive_raw(rq);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel = 1'b1;
      pwrite = write;
      paddr = {idx, 2'b00};
      pwdata = wdata;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic program_register(input reg_index_type idx, input int value);
      logic [31:0] readback;
      csr_access(idx, 1'b1, 32'(value), readback);
      tracker.set_register(idx, 32'(value));
      csr_access(idx, 1'b0, '0, readback);
      if (readback !== tracker.register_value(idx)) begin
         tracker.report_mismatch($sformatf("register %0d reads %h, expected %h", idx,
                                           readback, tracker.register_value(idx)));
      end
   endtask

   task automatic settle();
      start = 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_directed();
      send_request(make_request(KIND_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_LOAD, BUFFER_WORDS - 1, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_LOAD, BUFFER_WORDS, 32'h1234_5678, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_LOAD, 511, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_READ, 0, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_READ, BUFFER_WORDS - 1, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_READ, BUFFER_WORDS, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_READ, 511, 32'h0, 0, 0, 0, 0, 0));
      // Two consecutive patches of one word, then read it back.
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 0, 26, 63, 0));
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 0, 26, 32, 0));
      send_request(make_request(KIND_READ, 0, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 0, 26, 0, 1));
      // Last row of the last frame lands on the last buffer word.
      send_request(make_request(KIND_SET, 0, 32'h0, 49, 0, 29, 31, 1));
      send_request(make_request(KIND_READ, BUFFER_WORDS - 1, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_SET, 0, 32'h0, 25, 0, 27, 45, 1));
      send_request(make_request(KIND_SET, 0, 32'h0, 50, 0, 26, 40, 1));
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 1, 26, 40, 1));
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 0, 25, 40, 1));
      send_request(make_request(KIND_SET, 0, 32'h0, 0, 0, 30, 40, 1));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 0, 0, 0, 0, 0));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 49, 127, 0, 0, 0));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 50, 1, 0, 0, 0));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 149, 113, 0, 0, 0));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 150, 64, 0, 0, 0));
      send_request(make_request(KIND_LOCATE, 0, 32'h0, 255, 57, 0, 0, 0));
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      start = 1'b0;
      {req_kind, req_word_index, req_word_data, req_tile_row, req_tile_col,
       req_frame_id, req_bit_number, req_bit_value} = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      run_directed();
      foreach (PHASE_BASE[p]) begin
         settle();
         program_register(REG_FRAME_BASE, PHASE_BASE[p]);
         program_register(REG_ANCHOR_ROW, PHASE_ROW[p]);
         program_register(REG_ANCHOR_COL, PHASE_COL[p]);
         have_last_patch = 1'b0;
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
      settle();

      $display("covered %0d transactions: %0d loads, %0d bit patches, %0d reads, %0d locates",
               tracker.result_count, tracker.kind_count[KIND_LOAD],
               tracker.kind_count[KIND_SET], tracker.kind_count[KIND_READ],
               tracker.kind_count[KIND_LOCATE]);
      $display("statuses: %0d ok, %0d outside buffer, %0d wrong group; %0d register writes",
               tracker.status_count[STATUS_OK], tracker.status_count[STATUS_RANGE],
               tracker.status_count[STATUS_GROUP], tracker.register_writes);
      if (tracker.mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/cfbp_pkg.sv
rtl/core/cfbp_ram.sv
rtl/core/cfbp_locate.sv
rtl/core/config_frame_bit_patcher_top.sv
tb/sv/config_frame_bit_patcher_top_test.sv
